// ----- sv/assert_macros.svh -----
// Assertion helpers for the checker file kss_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/kss_pkg.sv -----
`timescale 1ns / 1ps
package kss_pkg;

	localparam int DATA_W = 32;
	localparam int CFG_W  = 4;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_INSERT_POP,
		CELL_POP
	} cell_op_t;

	typedef enum logic {
		ST_RUN,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		cell_op_t                  op;
		logic signed [DATA_W-1:0]  value;
	} kss_ctl_t;

endpackage

// ----- sv/k_sorted_stream_sorter.sv -----
`timescale 1ns / 1ps
// Sorts a stream in which every value lies at most window_k places from its
// sorted place, ascending by signed value. The values are held in a row of
// MAX_WINDOW+1 cells kept in order; each input transfer inserts its value,
// and once window_k+1 values are held the smallest leaves in that same
// cycle, so the block takes one item per clock while the output is taken.
// After the transfer marked end_of_stream the input stalls while the cells
// drain, one held value per cycle, the final one flagged by last. The output
// register sets the pace on the output side: while it is stalled the input
// is stalled too. window_k above MAX_WINDOW acts as MAX_WINDOW; the user
// must change it only between streams, which the block does not enforce.
module k_sorted_stream_sorter import kss_pkg::*; #(
	parameter int MAX_WINDOW = 15
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_W-1:0]          cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [DATA_W-1:0]  value,
	input  logic                      end_of_stream,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [DATA_W-1:0]  sorted_value,
	output logic                      last
);

	localparam int DEPTH = MAX_WINDOW + 1;
	localparam int CW    = $clog2(DEPTH + 1);

	logic [CFG_W-1:0]          window_k_q;
	logic [CW-1:0]             count_q;
	logic [CW-1:0]             count_d;
	logic [CW-1:0]             k_eff;
	state_t                    state_q;
	state_t                    state_d;
	logic                      out_valid_q;
	logic signed [DATA_W-1:0]  out_value_q;
	logic                      out_last_q;
	logic                      out_free;
	logic                      accept;
	logic                      need_pop;
	logic                      drain_pop;
	logic                      load_out;
	logic signed [DATA_W-1:0]  load_value;
	logic                      load_last;
	kss_ctl_t                  ctl;

	logic signed [DATA_W-1:0]  cell_value [DEPTH];
	logic                      cell_lt    [DEPTH];
	logic                      cell_valid [DEPTH];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_k_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			window_k_q <= cfg_data;
		end
	end

	assign k_eff = (32'(window_k_q) > MAX_WINDOW) ? CW'(MAX_WINDOW) : CW'(window_k_q);

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q == ST_DRAIN) || !out_free;
	assign accept    = in_valid && !in_stall;
	// After insertion the count is count_q+1; a value leaves when that reaches k+1.
	assign need_pop  = count_q >= k_eff;
	assign drain_pop = (state_q == ST_DRAIN) && out_free;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_RUN: begin
				if (accept && end_of_stream && (count_d != '0)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (drain_pop && (count_q == CW'(1))) begin
					state_d = ST_RUN;
				end
			end
			default: state_d = ST_RUN;
		endcase
	end

	// Cell control, count update and output load.
	always_comb begin
		ctl.op     = CELL_HOLD;
		ctl.value  = value;
		count_d    = count_q;
		load_out   = 1'b0;
		load_value = cell_value[0];
		load_last  = 1'b0;
		if (accept) begin
			if (need_pop) begin
				ctl.op     = CELL_INSERT_POP;
				load_out   = 1'b1;
				load_value = cell_lt[0] ? value : cell_value[0];
				load_last  = end_of_stream && (count_q == '0);
			end else begin
				ctl.op  = CELL_INSERT;
				count_d = count_q + CW'(1);
			end
		end else if (drain_pop) begin
			ctl.op     = CELL_POP;
			count_d    = count_q - CW'(1);
			load_out   = 1'b1;
			load_last  = count_q == CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_value_q <= load_value;
			out_last_q  <= load_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign sorted_value = out_value_q;
	assign last         = out_last_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign cell_valid[i] = CW'(i) < count_q;

		if (i == 0) begin : g_head
			if (DEPTH == 1) begin : g_only
				kss_cell u_cell (
					.clk        (clk),
					.ctl        (ctl),
					.valid      (cell_valid[i]),
					.prev_value (value),
					.prev_lt    (1'b0),
					.next_value (cell_value[i]),
					.next_lt    (1'b1),
					.value_out  (cell_value[i]),
					.lt         (cell_lt[i])
				);
			end else begin : g_first
				kss_cell u_cell (
					.clk        (clk),
					.ctl        (ctl),
					.valid      (cell_valid[i]),
					.prev_value (value),
					.prev_lt    (1'b0),
					.next_value (cell_value[i+1]),
					.next_lt    (cell_lt[i+1]),
					.value_out  (cell_value[i]),
					.lt         (cell_lt[i])
				);
			end
		end else if (i == DEPTH - 1) begin : g_tail
			kss_cell u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.valid      (cell_valid[i]),
				.prev_value (cell_value[i-1]),
				.prev_lt    (cell_lt[i-1]),
				.next_value (cell_value[i]),
				.next_lt    (1'b1),
				.value_out  (cell_value[i]),
				.lt         (cell_lt[i])
			);
		end else begin : g_mid
			kss_cell u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.valid      (cell_valid[i]),
				.prev_value (cell_value[i-1]),
				.prev_lt    (cell_lt[i-1]),
				.next_value (cell_value[i+1]),
				.next_lt    (cell_lt[i+1]),
				.value_out  (cell_value[i]),
				.lt         (cell_lt[i])
			);
		end
	end

endmodule

// ----- sv/kss_cell.sv -----
`timescale 1ns / 1ps
module kss_cell import kss_pkg::*; (
	input  logic                      clk,
	input  kss_ctl_t                  ctl,
	input  logic                      valid,
	input  logic signed [DATA_W-1:0]  prev_value,
	input  logic                      prev_lt,
	input  logic signed [DATA_W-1:0]  next_value,
	input  logic                      next_lt,
	output logic signed [DATA_W-1:0]  value_out,
	output logic                      lt
);

	logic signed [DATA_W-1:0] value_q;
	logic signed [DATA_W-1:0] ins_here;
	logic signed [DATA_W-1:0] ins_next;
	logic signed [DATA_W-1:0] value_d;

	// An empty cell counts as larger than any incoming value, so the new
	// value lands in the first slot whose occupant exceeds it.
	assign lt = !valid || (ctl.value < value_q);

	// Contents of this slot and of the next slot once the new value is placed.
	assign ins_here = lt ? (prev_lt ? prev_value : ctl.value) : value_q;
	assign ins_next = next_lt ? (lt ? value_q : ctl.value) : next_value;

	always_comb begin
		case (ctl.op)
			CELL_INSERT:     value_d = ins_here;
			CELL_INSERT_POP: value_d = ins_next;
			CELL_POP:        value_d = next_value;
			default:         value_d = value_q;
		endcase
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

	assign value_out = value_q;

endmodule

// ----- sv/kss_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module kss_checker import kss_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      end_of_stream,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic signed [DATA_W-1:0]  sorted_value,
	input logic                      last
);

	// A waiting result that is held back must keep the input side stalled.
	`ASSERT_SAME(a_back_pressure, clk, arst_n, out_valid && out_stall, in_stall, "input taken while output stalled")

	// The stream end either finishes at once with a flagged result or starts the drain.
	`ASSERT_NEXT(a_end_drains, clk, arst_n, in_valid && !in_stall && end_of_stream, in_stall || (out_valid && last), "no drain after end of stream")

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(sorted_value) && $stable(last), "stalled result changed")

	`ASSERT_SAME(a_out_drop, clk, arst_n, $fell(out_valid), $past(!out_stall), "result dropped without transfer")

endmodule

bind k_sorted_stream_sorter kss_checker u_kss_checker (.*);
